// ===== hw/rtl/swh_pkg.sv =====
// Shared types and constants for the spatial weight Hadamard unit.
// No dependencies; every other file in this folder imports this package.
`timescale 1ns / 1ps
`default_nettype none

package swh_pkg;

    // Default sizes, handed to the top level parameters
    localparam int PLANE_MAX_DEF  = 4096;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int GRAD_WIDTH_DEF = 48;

    // Fixed field widths
    localparam int PLANE_SIZE_W = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int ACTION_W     = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PLANE_SIZE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WGRAD_EN   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DGRAD_EN   = 2'd2;

    // Item actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD      = 2'd0,
        ACT_FORWARD   = 2'd1,
        ACT_BACKWARD  = 2'd2,
        ACT_READ_GRAD = 2'd3
    } swh_action_t;

    // Pipeline strobes shared by the datapath modules
    typedef struct packed {
        logic accept;   // item enters stage 1, memories are read
        logic s1_adv;   // stage 1 moves to stage 2, gradient write back
    } swh_flow_t;

endpackage

`default_nettype wire

// ===== hw/rtl/swh_pos_ctrl.sv =====
// Spatial position counter with plane wrap and first-plane flag.
// Depends on swh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swh_pos_ctrl
    import swh_pkg::*;
#(
    parameter int PLANE_MAX = PLANE_MAX_DEF,
    parameter int ADDR_W    = 12
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire logic                    restart,
    input  wire logic [PLANE_SIZE_W-1:0] plane_size,
    output logic      [ADDR_W-1:0]       pos,
    output logic                         first
);

    localparam int CNT_W = (ADDR_W + 1 > PLANE_SIZE_W) ? ADDR_W + 1 : PLANE_SIZE_W;
    localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'(PLANE_MAX);

    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] pos_next;
    logic              first_reg;
    logic              first_next;
    logic [CNT_W-1:0]  size_ext;
    logic [CNT_W-1:0]  limit;
    logic [CNT_W-1:0]  pos_inc;

    // Clamp the configured plane size into 1..PLANE_MAX
    always_comb
    begin
        size_ext = CNT_W'(plane_size);
        if (size_ext == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (size_ext > LIMIT_MAX)
        begin
            limit = LIMIT_MAX;
        end
        else
        begin
            limit = size_ext;
        end
    end

    // Restart applies before the item uses the position
    assign pos   = restart ? '0 : pos_reg;
    assign first = restart | first_reg;

    // Advance and wrap
    always_comb
    begin
        pos_inc = CNT_W'(pos) + CNT_W'(1);
        if (pos_inc >= limit)
        begin
            pos_next   = '0;
            first_next = 1'b0;
        end
        else
        begin
            pos_next   = pos_inc[ADDR_W-1:0];
            first_next = first;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            first_reg <= first_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/swh_weight_path.sv =====
// Weight memory, weight multiply and rounding/saturation to the data format.
// Depends on swh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swh_weight_path
    import swh_pkg::*;
#(
    parameter int PLANE_MAX  = PLANE_MAX_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int ADDR_W     = 12
)
(
    input  wire logic                         clk,
    input  wire swh_flow_t                    flow,
    input  wire logic                         load,
    input  wire logic        [ADDR_W-1:0]     addr,
    input  wire logic signed [DATA_WIDTH-1:0] value_a,
    output logic signed      [DATA_WIDTH-1:0] product
);

    localparam int FRAC  = DATA_WIDTH - 4;
    localparam int MUL_W = 2 * DATA_WIDTH;
    localparam int RND_W = MUL_W + 1;
    localparam logic signed [RND_W-1:0] HALF =
        {{(RND_W - FRAC){1'b0}}, 1'b1, {(FRAC - 1){1'b0}}};
    localparam logic signed [RND_W-1:0] SAT_HI =
        {{(DATA_WIDTH + 2){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [RND_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [DATA_WIDTH-1:0] weight_mem [PLANE_MAX];
    logic signed [DATA_WIDTH-1:0] w_rdata_reg;
    logic signed [DATA_WIDTH-1:0] s1_a_reg;
    logic signed [MUL_W-1:0]      mul_next;
    logic signed [MUL_W-1:0]      mul_reg;
    logic signed [RND_W-1:0]      biased;
    logic signed [RND_W-1:0]      shifted;

    // Write a loaded weight, read the entry for the entering item
    always_ff @(posedge clk)
    begin
        if (flow.accept)
        begin
            if (load)
            begin
                weight_mem[addr] <= value_a;
            end
            w_rdata_reg <= weight_mem[addr];
            s1_a_reg    <= value_a;
        end
    end

    // Stage 1: multiply by the weight
    assign mul_next = s1_a_reg * w_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (flow.s1_adv)
        begin
            mul_reg <= mul_next;
        end
    end

    // Stage 2: round half up, then saturate
    always_comb
    begin
        biased  = RND_W'(mul_reg) + HALF;
        shifted = biased >>> FRAC;
        if (shifted > SAT_HI)
        begin
            product = SAT_HI[DATA_WIDTH-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            product = SAT_LO[DATA_WIDTH-1:0];
        end
        else
        begin
            product = shifted[DATA_WIDTH-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/swh_grad_path.sv =====
// Weight-gradient memory with read-modify-write, saturating accumulate
// and write-back forwarding. Depends on swh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swh_grad_path
    import swh_pkg::*;
#(
    parameter int PLANE_MAX  = PLANE_MAX_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int GRAD_WIDTH = GRAD_WIDTH_DEF,
    parameter int ADDR_W     = 12
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire swh_flow_t                    flow,
    input  wire logic        [ADDR_W-1:0]     addr,
    input  wire logic                         accumulate,
    input  wire logic                         read_grad,
    input  wire logic                         first,
    input  wire logic signed [DATA_WIDTH-1:0] value_a,
    input  wire logic signed [DATA_WIDTH-1:0] value_b,
    output logic signed      [GRAD_WIDTH-1:0] grad_value
);

    localparam int MUL_W = 2 * DATA_WIDTH;
    localparam int SUM_W = ((MUL_W > GRAD_WIDTH) ? MUL_W : GRAD_WIDTH) + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W - GRAD_WIDTH + 1){1'b0}}, {(GRAD_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [GRAD_WIDTH-1:0] grad_mem [PLANE_MAX];
    logic signed [GRAD_WIDTH-1:0] g_rdata_reg;
    logic signed [MUL_W-1:0]      ab_reg;
    logic        [ADDR_W-1:0]     s1_addr_reg;
    logic                         s1_acc_reg;
    logic                         s1_read_reg;
    logic                         s1_first_reg;
    logic                         fwd_hit_reg;
    logic                         fwd_hit_next;
    logic signed [GRAD_WIDTH-1:0] fwd_data_reg;
    logic signed [GRAD_WIDTH-1:0] grad_old;
    logic signed [GRAD_WIDTH-1:0] grad_new;
    logic signed [SUM_W-1:0]      sum;
    logic signed [GRAD_WIDTH-1:0] s2_grad_reg;

    // Stage 0: read the entry, form the exact gradient product
    always_ff @(posedge clk)
    begin
        if (flow.accept)
        begin
            g_rdata_reg  <= grad_mem[addr];
            ab_reg       <= value_a * value_b;
            s1_addr_reg  <= addr;
            s1_acc_reg   <= accumulate;
            s1_read_reg  <= read_grad;
            s1_first_reg <= first;
            fwd_data_reg <= grad_new;
        end
        if (flow.s1_adv && s1_acc_reg)
        begin
            grad_mem[s1_addr_reg] <= grad_new;
        end
    end

    // Forward the write-back when the entering item reads the same entry
    assign fwd_hit_next = flow.s1_adv && s1_acc_reg && (s1_addr_reg == addr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (flow.accept)
        begin
            fwd_hit_reg <= fwd_hit_next;
        end
    end

    // Stage 1: overwrite on the first plane, else saturating add
    always_comb
    begin
        grad_old = fwd_hit_reg ? fwd_data_reg : g_rdata_reg;
        sum      = SUM_W'(grad_old) + SUM_W'(ab_reg);
        if (s1_first_reg)
        begin
            grad_new = GRAD_WIDTH'(ab_reg);
        end
        else if (sum > SAT_HI)
        begin
            grad_new = SAT_HI[GRAD_WIDTH-1:0];
        end
        else if (sum < SAT_LO)
        begin
            grad_new = SAT_LO[GRAD_WIDTH-1:0];
        end
        else
        begin
            grad_new = sum[GRAD_WIDTH-1:0];
        end
    end

    // Stage 2: hold the entry for a read item, zero otherwise
    always_ff @(posedge clk)
    begin
        if (flow.s1_adv)
        begin
            s2_grad_reg <= s1_read_reg ? grad_old : '0;
        end
    end

    assign grad_value = s2_grad_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/spatial_weight_hadamard_unit.sv =====
// Top level of the spatial weight Hadamard unit: configuration registers,
// pipeline control and output register. Depends on swh_pkg, swh_pos_ctrl,
// swh_weight_path and swh_grad_path.
//
//   channel   direction  handshake             payload
//   input     in         in_valid / in_stall   action, restart, value_a, value_b
//   result    out        out_valid / out_stall product, product_valid,
//                                              grad_value, position
//   config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; after acceptance a result
// passes memory read, multiply/accumulate and round into the output register, in that order.
// Rate is set by the single read and write port of each memory; gradient
// read-modify-write hazards are covered by forwarding, not stalls.
// Reset clears position and valid bits, sets the first-plane flag, loads configuration
// defaults (plane size 1, gradients on); memories hold nothing defined until written.
// in_stall rises only when every stage is full and out_stall is high.
`timescale 1ns / 1ps
`default_nettype none

module spatial_weight_hadamard_unit
    import swh_pkg::*;
#(
    parameter  int PLANE_MAX  = PLANE_MAX_DEF,
    parameter  int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter  int GRAD_WIDTH = GRAD_WIDTH_DEF,
    localparam int ADDR_W     = (PLANE_MAX > 1) ? $clog2(PLANE_MAX) : 1
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // input items
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic        [ACTION_W-1:0]   action,
    input  wire logic                         restart,
    input  wire logic signed [DATA_WIDTH-1:0] value_a,
    input  wire logic signed [DATA_WIDTH-1:0] value_b,
    // result items
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed      [DATA_WIDTH-1:0] product,
    output logic                              product_valid,
    output logic signed      [GRAD_WIDTH-1:0] grad_value,
    output logic             [ADDR_W-1:0]     position,
    // configuration writes
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic        [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic        [PLANE_SIZE_W-1:0] cfg_data
);

    swh_flow_t   flow;
    swh_action_t act;

    logic [PLANE_SIZE_W-1:0] plane_size_reg;
    logic                    wgrad_en_reg;
    logic                    dgrad_en_reg;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_pvalid_reg;
    logic [ADDR_W-1:0]     s1_pos_reg;
    logic                  s2_valid_reg;
    logic                  s2_valid_next;
    logic                  s2_pvalid_reg;
    logic [ADDR_W-1:0]     s2_pos_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic                  out_ready;
    logic                  s2_ready;
    logic                  s1_ready;
    logic                  s2_adv;
    logic [ADDR_W-1:0]     pos;
    logic                  first;
    logic                  pvalid_in;
    logic signed [DATA_WIDTH-1:0] rnd_product;
    logic signed [GRAD_WIDTH-1:0] s2_grad;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_size_reg <= PLANE_SIZE_W'(1);
            wgrad_en_reg   <= 1'b1;
            dgrad_en_reg   <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PLANE_SIZE: plane_size_reg <= cfg_data;
                CFG_WGRAD_EN:   wgrad_en_reg   <= cfg_data[0];
                CFG_DGRAD_EN:   dgrad_en_reg   <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Pipeline flow: a stage moves when the next one is empty or moving
    assign out_ready   = !out_valid_reg || !out_stall;
    assign s2_adv      = s2_valid_reg && out_ready;
    assign s2_ready    = !s2_valid_reg || out_ready;
    assign flow.s1_adv = s1_valid_reg && s2_ready;
    assign s1_ready    = !s1_valid_reg || s2_ready;
    assign in_stall    = !s1_ready;
    assign flow.accept = in_valid && s1_ready;

    assign s1_valid_next  = flow.accept ? 1'b1 : (flow.s1_adv ? 1'b0 : s1_valid_reg);
    assign s2_valid_next  = flow.s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_reg);
    assign out_valid_next = s2_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Decode the entering item
    assign act       = swh_action_t'(action);
    assign pvalid_in = (act == ACT_FORWARD) || ((act == ACT_BACKWARD) && dgrad_en_reg);

    // Carry position and product flag along the stages
    always_ff @(posedge clk)
    begin
        if (flow.accept)
        begin
            s1_pvalid_reg <= pvalid_in;
            s1_pos_reg    <= pos;
        end
        if (flow.s1_adv)
        begin
            s2_pvalid_reg <= s1_pvalid_reg;
            s2_pos_reg    <= s1_pos_reg;
        end
        if (s2_adv)
        begin
            product       <= s2_pvalid_reg ? rnd_product : '0;
            product_valid <= s2_pvalid_reg;
            grad_value    <= s2_grad;
            position      <= s2_pos_reg;
        end
    end

    assign out_valid = out_valid_reg;

    swh_pos_ctrl #(
        .PLANE_MAX (PLANE_MAX),
        .ADDR_W    (ADDR_W)
    ) u_pos_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (flow.accept),
        .restart    (restart),
        .plane_size (plane_size_reg),
        .pos        (pos),
        .first      (first)
    );

    swh_weight_path #(
        .PLANE_MAX  (PLANE_MAX),
        .DATA_WIDTH (DATA_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_weight_path (
        .clk     (clk),
        .flow    (flow),
        .load    (act == ACT_LOAD),
        .addr    (pos),
        .value_a (value_a),
        .product (rnd_product)
    );

    swh_grad_path #(
        .PLANE_MAX  (PLANE_MAX),
        .DATA_WIDTH (DATA_WIDTH),
        .GRAD_WIDTH (GRAD_WIDTH),
        .ADDR_W     (ADDR_W)
    ) u_grad_path (
        .clk        (clk),
        .rst_n      (rst_n),
        .flow       (flow),
        .addr       (pos),
        .accumulate ((act == ACT_BACKWARD) && wgrad_en_reg),
        .read_grad  (act == ACT_READ_GRAD),
        .first      (first),
        .value_a    (value_a),
        .value_b    (value_b),
        .grad_value (s2_grad)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/swh_checker.sv =====
// Port-level checks for spatial_weight_hadamard_unit and the bind that
// attaches them. Depends on swh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swh_checker
    import swh_pkg::*;
#(
    parameter  int PLANE_MAX  = PLANE_MAX_DEF,
    parameter  int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter  int GRAD_WIDTH = GRAD_WIDTH_DEF,
    localparam int ADDR_W     = (PLANE_MAX > 1) ? $clog2(PLANE_MAX) : 1
)
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic        [ACTION_W-1:0]    action,
    input wire logic                          restart,
    input wire logic signed [DATA_WIDTH-1:0]  value_a,
    input wire logic signed [DATA_WIDTH-1:0]  value_b,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic signed [DATA_WIDTH-1:0]  product,
    input wire logic                          product_valid,
    input wire logic signed [GRAD_WIDTH-1:0]  grad_value,
    input wire logic        [ADDR_W-1:0]      position,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready,
    input wire logic        [CFG_INDEX_W-1:0] cfg_index,
    input wire logic        [PLANE_SIZE_W-1:0] cfg_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(product) &&
            $stable(product_valid) && $stable(grad_value) && $stable(position))
        else $error("stalled result changed");

    // Stall input only when the output is backed up
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

    // Drop product when it is not meaningful
    a_product_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !product_valid |-> product == '0)
        else $error("product nonzero without product_valid");

    // A gradient read gives no product
    a_grad_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (grad_value != '0) |-> !product_valid)
        else $error("gradient and product in one result");

endmodule

bind spatial_weight_hadamard_unit swh_checker #(
    .PLANE_MAX  (PLANE_MAX),
    .DATA_WIDTH (DATA_WIDTH),
    .GRAD_WIDTH (GRAD_WIDTH)
) u_swh_checker (.*);

`default_nettype wire
